@@ rtl/core/ts2ep_pkg.sv @@
`default_nettype none

package ts2ep_pkg;

	// Widest accepted fraction, in digits.
	localparam int unsigned FRACTION_DIGITS = 9;
	// Length of "YYYY-MM-DD HH:MM:SS"; the fraction dot sits at this position.
	localparam int unsigned BASE_LEN = 19;
	localparam int unsigned NS_DIGITS = 9;

	localparam logic [7:0] CHAR_DASH  = 8'h2D;
	localparam logic [7:0] CHAR_COLON = 8'h3A;
	localparam logic [7:0] CHAR_DOT   = 8'h2E;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	// x / 25 == (x * DIV25_RECIP) >> DIV25_SHIFT for x below 2600.
	localparam int unsigned DIV25_RECIP = 1311;
	localparam int unsigned DIV25_SHIFT = 15;

	localparam int unsigned YEAR_SHIFT       = 400;
	localparam int unsigned DAYS_PER_YEAR    = 365;
	localparam int unsigned SEC_PER_DAY      = 86400;
	localparam int unsigned SEC_PER_HOUR     = 3600;
	localparam int unsigned SEC_PER_MIN      = 60;
	localparam int unsigned CENTURY          = 100;
	// Day count of 1970-01-01 from the shifted origin, plus one for the 1-based day.
	localparam int unsigned DAY_BASE_OFFSET  = 865566;
	localparam int unsigned NS_PER_SEC       = 1000000000;
	// Split point of the seconds value for the two partial products.
	localparam int unsigned SECS_SPLIT       = 31;

	// Limits of signed 64-bit nanoseconds, as seconds and nanosecond remainder.
	localparam logic signed [39:0] SECS_MAX = 40'sd9223372036;
	localparam logic signed [39:0] SECS_MIN = -40'sd9223372037;
	localparam logic [29:0] FRAC_AT_MAX     = 30'd854775807;
	localparam logic [29:0] FRAC_AT_MIN     = 30'd145224192;

	typedef enum logic [2:0] {
		ST_OK          = 3'd0,
		ST_FORMAT      = 3'd1,
		ST_NONDIGIT    = 3'd2,
		ST_RANGE       = 3'd3,
		ST_FRAC_SEP    = 3'd4,
		ST_FRAC_DIGITS = 3'd5,
		ST_OVERFLOW    = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_ADD,
		ACC_LOAD,
		ACC_LOAD_ADD
	} acc_op_t;

	typedef struct packed {
		logic signed [31:0] mul_a;
		logic [29:0]        mul_b;
		logic               mul_hi;
		acc_op_t            op;
		logic signed [63:0] load_val;
	} mac_ctl_t;

	function automatic logic [4:0] month_len(input logic [6:0] m, input logic leap);
		logic [4:0] len;
		case (m) inside
			7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: len = 5'd31;
			7'd4, 7'd6, 7'd9, 7'd11:                    len = 5'd30;
			7'd2:                                       len = leap ? 5'd29 : 5'd28;
			default:                                    len = 5'd0;
		endcase
		return len;
	endfunction

	// Days from March 1 to the first of the month, year starting in March.
	function automatic logic [8:0] month_offset(input logic [6:0] m);
		logic [8:0] off;
		case (m)
			7'd3:    off = 9'd0;
			7'd4:    off = 9'd31;
			7'd5:    off = 9'd61;
			7'd6:    off = 9'd92;
			7'd7:    off = 9'd122;
			7'd8:    off = 9'd153;
			7'd9:    off = 9'd184;
			7'd10:   off = 9'd214;
			7'd11:   off = 9'd245;
			7'd12:   off = 9'd275;
			7'd1:    off = 9'd306;
			7'd2:    off = 9'd337;
			default: off = 9'd0;
		endcase
		return off;
	endfunction

	function automatic logic [29:0] pow10(input logic [3:0] k);
		logic [29:0] v;
		case (k)
			4'd1:    v = 30'd10;
			4'd2:    v = 30'd100;
			4'd3:    v = 30'd1000;
			4'd4:    v = 30'd10000;
			4'd5:    v = 30'd100000;
			4'd6:    v = 30'd1000000;
			4'd7:    v = 30'd10000000;
			4'd8:    v = 30'd100000000;
			4'd9:    v = 30'd1000000000;
			default: v = 30'd1;
		endcase
		return v;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/timestamp_text_to_epoch_ns_top.sv @@
// Channel  Valid         Stall         Payload
// text     text_valid    text_stall    text_byte[7:0], last_byte
// result   result_valid  result_stall  epoch_ns[63:0] (signed), status[2:0]
//
// Text bytes are taken while collecting. After the final byte the text side stalls while
// one shared multiply-accumulate unit runs the conversion; a length, separator or digit
// error ends it at the first step, a range or fraction error at the day step, and the
// end waits while the result side stalls with the previous result unread.
// arst_n clears the sequencer, the field accumulators and the result valid.
`default_nettype none

module timestamp_text_to_epoch_ns_top
	import ts2ep_pkg::*;
#(
	parameter int unsigned FRAC_DIGITS = FRACTION_DIGITS
)
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               text_valid,
	output logic                    text_stall,
	input  wire logic [7:0]         text_byte,
	input  wire logic               last_byte,
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic signed [63:0]      epoch_ns,
	output logic [2:0]              status
);

	typedef enum logic [1:0] {
		S_COLLECT = 2'b01,
		S_CONVERT = 2'b10
	} state_t;

	localparam logic [3:0] STEP_Y_DIV   = 4'd0;
	localparam logic [3:0] STEP_YY_DIV  = 4'd1;
	localparam logic [3:0] STEP_DAYS    = 4'd2;
	localparam logic [3:0] STEP_YEARS   = 4'd3;
	localparam logic [3:0] STEP_TOD     = 4'd4;
	localparam logic [3:0] STEP_SECS    = 4'd5;
	localparam logic [3:0] STEP_NS_LO   = 4'd6;
	localparam logic [3:0] STEP_NS_HI   = 4'd7;
	localparam logic [3:0] STEP_SUM     = 4'd8;
	localparam logic [3:0] STEP_LAST    = 4'd9;

	state_t             state_q;
	logic [3:0]         step_q;
	logic [4:0]         pos_q;
	logic [13:0]        year_q;
	logic [6:0]         month_q;
	logic [6:0]         day_q;
	logic [6:0]         hour_q;
	logic [6:0]         minute_q;
	logic [6:0]         second_q;
	logic [29:0]        frac_q;
	logic [3:0]         fcount_q;
	logic [3:0]         err_q;
	logic [4:0]         last_pos_q;
	logic               leap_q;
	logic signed [39:0] secs_q;
	logic [29:0]        fracs_q;
	logic               out_valid_q;
	logic signed [63:0] epoch_q;
	status_t            status_q;

	mac_ctl_t           ctl;
	logic signed [63:0] prod;
	logic signed [63:0] acc;

	logic               accept;
	logic               is_digit;
	logic [3:0]         digit;
	logic [3:0]         fcount_n;
	logic [13:0]        yy;
	logic [6:0]         quot;
	logic               leap_n;
	logic [4:0]         mlen;
	logic               range_bad;
	logic signed [23:0] day_base;
	logic [12:0]        tod;
	logic               fits;
	status_t            early_code;
	status_t            late_code;
	status_t            fin_code;
	logic               done_here;
	logic               out_free;
	logic               finish_go;

	assign text_stall = (state_q != S_COLLECT);
	assign accept     = text_valid && !text_stall;
	assign is_digit   = (text_byte >= CHAR_ZERO) && (text_byte <= CHAR_NINE);
	assign digit      = text_byte[3:0];
	assign fcount_n   = (fcount_q < 4'd15) ? fcount_q + 4'd1 : fcount_q;

	// Collect fields, one text byte per item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			year_q     <= '0;
			month_q    <= '0;
			day_q      <= '0;
			hour_q     <= '0;
			minute_q   <= '0;
			second_q   <= '0;
			frac_q     <= '0;
			fcount_q   <= '0;
			err_q      <= '0;
			last_pos_q <= '0;
		end else if (finish_go) begin
			pos_q    <= '0;
			year_q   <= '0;
			month_q  <= '0;
			day_q    <= '0;
			hour_q   <= '0;
			minute_q <= '0;
			second_q <= '0;
			frac_q   <= '0;
			fcount_q <= '0;
			err_q    <= '0;
		end else if (accept) begin
			case (pos_q) inside
				[5'd0:5'd3]: begin
					if (is_digit) year_q <= 14'(year_q * 14'd10 + {10'd0, digit});
					else err_q[1] <= 1'b1;
				end
				5'd4, 5'd7: begin
					if (text_byte != CHAR_DASH) err_q[0] <= 1'b1;
				end
				5'd5, 5'd6: begin
					if (is_digit) month_q <= 7'(month_q * 7'd10 + {3'd0, digit});
					else err_q[1] <= 1'b1;
				end
				5'd8, 5'd9: begin
					if (is_digit) day_q <= 7'(day_q * 7'd10 + {3'd0, digit});
					else err_q[1] <= 1'b1;
				end
				5'd10: begin
					if (text_byte != CHAR_SPACE) err_q[0] <= 1'b1;
				end
				5'd11, 5'd12: begin
					if (is_digit) hour_q <= 7'(hour_q * 7'd10 + {3'd0, digit});
					else err_q[1] <= 1'b1;
				end
				5'd13, 5'd16: begin
					if (text_byte != CHAR_COLON) err_q[0] <= 1'b1;
				end
				5'd14, 5'd15: begin
					if (is_digit) minute_q <= 7'(minute_q * 7'd10 + {3'd0, digit});
					else err_q[1] <= 1'b1;
				end
				5'd17, 5'd18: begin
					if (is_digit) second_q <= 7'(second_q * 7'd10 + {3'd0, digit});
					else err_q[1] <= 1'b1;
				end
				5'd19: begin
					if (text_byte != CHAR_DOT) err_q[2] <= 1'b1;
				end
				default: begin
					fcount_q <= fcount_n;
					if (!is_digit || fcount_n > 4'(FRAC_DIGITS)) err_q[3] <= 1'b1;
					else frac_q <= 30'(frac_q * 30'd10 + {26'd0, digit});
				end
			endcase
			if (pos_q != 5'd31) pos_q <= pos_q + 5'd1;
			if (last_byte) last_pos_q <= pos_q;
		end
	end

	// Shifted year keeps the day count positive; Jan and Feb count with the year before.
	assign yy       = year_q + 14'(YEAR_SHIFT) - {13'd0, month_q <= 7'd2};
	assign quot     = prod[DIV25_SHIFT +: 7];
	assign leap_n   = (year_q[1:0] == 2'd0) &&
		((year_q != 14'(quot) * 14'(CENTURY)) || (quot[1:0] == 2'd0));
	assign mlen     = month_len(month_q, leap_q);
	assign range_bad = (month_q < 7'd1) || (month_q > 7'd12) || (day_q < 7'd1) ||
		(day_q > {2'd0, mlen}) || (hour_q > 7'd23) || (minute_q > 7'd59) ||
		(second_q > 7'd59);
	assign day_base = 24'(yy >> 2) - 24'(quot) + 24'(quot >> 2) +
		24'(month_offset(month_q)) + 24'(day_q) - 24'(DAY_BASE_OFFSET);
	assign tod      = 13'(minute_q) * 13'(SEC_PER_MIN) + 13'(second_q);
	assign fits     = ((secs_q > SECS_MIN) && (secs_q < SECS_MAX)) ||
		((secs_q == SECS_MAX) && (fracs_q <= FRAC_AT_MAX)) ||
		((secs_q == SECS_MIN) && (fracs_q >= FRAC_AT_MIN));

	always_comb begin
		if ((last_pos_q < 5'(BASE_LEN - 1)) || err_q[0]) early_code = ST_FORMAT;
		else if (err_q[1])                               early_code = ST_NONDIGIT;
		else                                             early_code = ST_OK;
	end

	always_comb begin
		if (range_bad)
			late_code = ST_RANGE;
		else if ((last_pos_q > 5'(BASE_LEN - 1)) && err_q[2])
			late_code = ST_FRAC_SEP;
		else if ((last_pos_q > 5'(BASE_LEN - 1)) &&
				((last_pos_q == 5'(BASE_LEN)) || err_q[3]))
			late_code = ST_FRAC_DIGITS;
		else
			late_code = ST_OK;
	end

	// Sequence the shared unit: a product issued in one step is read or added in the next.
	always_comb begin
		ctl          = '0;
		ctl.op       = ACC_HOLD;
		done_here    = 1'b0;
		fin_code     = ST_OK;
		if (state_q == S_CONVERT) begin
			unique case (step_q)
				STEP_Y_DIV: begin
					ctl.mul_a = $signed(32'(year_q >> 2));
					ctl.mul_b = 30'(DIV25_RECIP);
					done_here = (early_code != ST_OK);
					fin_code  = early_code;
				end
				STEP_YY_DIV: begin
					ctl.mul_a = $signed(32'(yy >> 2));
					ctl.mul_b = 30'(DIV25_RECIP);
				end
				STEP_DAYS: begin
					ctl.mul_a    = $signed(32'(yy));
					ctl.mul_b    = 30'(DAYS_PER_YEAR);
					ctl.op       = ACC_LOAD;
					ctl.load_val = 64'(day_base);
					done_here    = (late_code != ST_OK);
					fin_code     = late_code;
				end
				STEP_YEARS: begin
					ctl.mul_a = $signed(32'(hour_q));
					ctl.mul_b = 30'(SEC_PER_HOUR);
					ctl.op    = ACC_ADD;
				end
				STEP_TOD: begin
					ctl.mul_a    = $signed(acc[31:0]);
					ctl.mul_b    = 30'(SEC_PER_DAY);
					ctl.op       = ACC_LOAD_ADD;
					ctl.load_val = 64'(tod);
				end
				STEP_SECS: begin
					ctl.mul_a = $signed(32'(frac_q));
					ctl.mul_b = pow10(4'(NS_DIGITS) - fcount_q);
					ctl.op    = ACC_ADD;
				end
				STEP_NS_LO: begin
					ctl.mul_a = $signed({1'b0, acc[30:0]});
					ctl.mul_b = 30'(NS_PER_SEC);
					ctl.op    = ACC_LOAD_ADD;
				end
				STEP_NS_HI: begin
					ctl.mul_a  = 32'($signed(secs_q[39:31]));
					ctl.mul_b  = 30'(NS_PER_SEC);
					ctl.mul_hi = 1'b1;
					ctl.op     = ACC_ADD;
				end
				STEP_SUM: begin
					ctl.op = ACC_ADD;
				end
				STEP_LAST: begin
					done_here = 1'b1;
					fin_code  = fits ? ST_OK : ST_OVERFLOW;
				end
				default: begin
					done_here = 1'b1;
					fin_code  = ST_OVERFLOW;
				end
			endcase
		end
	end

	assign out_free  = !out_valid_q || !result_stall;
	assign finish_go = done_here && out_free;

	ts2ep_mac u_mac (
		.clk  (clk),
		.ctl  (ctl),
		.prod (prod),
		.acc  (acc)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COLLECT;
			step_q  <= STEP_Y_DIV;
		end else begin
			unique case (state_q)
				S_COLLECT: begin
					if (accept && last_byte) begin
						state_q <= S_CONVERT;
						step_q  <= STEP_Y_DIV;
					end
				end
				S_CONVERT: begin
					if (finish_go) state_q <= S_COLLECT;
					else if (!done_here) step_q <= step_q + 4'd1;
				end
				default: state_q <= S_COLLECT;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_CONVERT && step_q == STEP_YY_DIV) leap_q <= leap_n;
		if (state_q == S_CONVERT && step_q == STEP_NS_LO) begin
			secs_q  <= acc[39:0];
			fracs_q <= prod[29:0];
		end
		if (finish_go) begin
			status_q <= fin_code;
			epoch_q  <= (fin_code == ST_OK) ? acc : 64'sd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign result_valid = out_valid_q;
	assign epoch_ns     = epoch_q;
	assign status       = status_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CONVERT |-> step_q <= STEP_LAST)
		else $error("conversion step past the last one");

	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && last_byte) |=> (state_q == S_CONVERT && step_q == STEP_Y_DIV))
		else $error("final byte did not start the conversion");

	a_rose_from_convert: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(state_q == S_CONVERT))
		else $error("result appeared without a conversion");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != ST_OK) |-> epoch_ns == 64'sd0)
		else $error("failed item carries a nonzero value");

	a_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_COLLECT && $past(state_q == S_CONVERT)) |->
			(pos_q == 5'd0 && err_q == 4'd0 && fcount_q == 4'd0))
		else $error("collector not cleared after a result");

endmodule

`default_nettype wire

@@ rtl/core/ts2ep_mac.sv @@
`default_nettype none

module ts2ep_mac
	import ts2ep_pkg::*;
(
	input  wire logic               clk,
	input  mac_ctl_t                ctl,
	output logic signed [63:0]      prod,
	output logic signed [63:0]      acc
);

	logic signed [62:0] mul_p;
	logic signed [63:0] mul_ext;
	logic signed [63:0] prod_q;
	logic signed [63:0] acc_q;

	assign mul_p   = 63'(ctl.mul_a) * 63'($signed({1'b0, ctl.mul_b}));
	assign mul_ext = 64'(mul_p);

	always_ff @(posedge clk) begin
		prod_q <= ctl.mul_hi ? (mul_ext <<< SECS_SPLIT) : mul_ext;
		unique case (ctl.op)
			ACC_HOLD:     acc_q <= acc_q;
			ACC_ADD:      acc_q <= acc_q + prod_q;
			ACC_LOAD:     acc_q <= ctl.load_val;
			ACC_LOAD_ADD: acc_q <= ctl.load_val + prod_q;
		endcase
	end

	assign prod = prod_q;
	assign acc  = acc_q;

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import ts2ep_pkg::*;

	localparam int LIMIT_CYCLES = 200000;
	localparam int RANDOM_BYTES = 790;
	localparam int PRESSURE_CYCLES = 400;

	typedef logic [7:0] text_q_t[$];

	class epoch_scoreboard;
		int pos;
		int yr, mon, dy, hr, mi, sc;
		int fr, fcnt;
		logic [3:0] err;
		logic signed [63:0] exp_ns[$];
		status_t exp_st[$];
		int errors;

		function new();
			errors = 0;
			clear();
		endfunction

		function void clear();
			pos = 0;
			yr = 0;
			mon = 0;
			dy = 0;
			hr = 0;
			mi = 0;
			sc = 0;
			fr = 0;
			fcnt = 0;
			err = '0;
		endfunction

		function int push_digit(int acc, logic [7:0] b, int mask);
			if (b >= CHAR_ZERO && b <= CHAR_NINE)
				return (acc * 10 + (int'(b) - int'(CHAR_ZERO))) & mask;
			err[1] = 1'b1;
			return acc;
		endfunction

		function int days_in_month(int y, int m);
			bit leap;
			leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
			case (m) inside
				1, 3, 5, 7, 8, 10, 12: return 31;
				4, 6, 9, 11:           return 30;
				2:                     return leap ? 29 : 28;
				default:               return 0;
			endcase
		endfunction

		function void take_byte(logic [7:0] b, logic fin);
			int p, len, mp, i;
			bit dig, fits;
			status_t st;
			longint yy, days, secs, frac_ns;
			logic signed [63:0] ns;
			p = pos;
			dig = (b >= CHAR_ZERO && b <= CHAR_NINE);
			if (p <= 3)
				yr = push_digit(yr, b, 'h3FFF);
			else if (p == 4 || p == 7) begin
				if (b != CHAR_DASH) err[0] = 1'b1;
			end else if (p == 5 || p == 6)
				mon = push_digit(mon, b, 'h7F);
			else if (p == 8 || p == 9)
				dy = push_digit(dy, b, 'h7F);
			else if (p == 10) begin
				if (b != CHAR_SPACE) err[0] = 1'b1;
			end else if (p == 11 || p == 12)
				hr = push_digit(hr, b, 'h7F);
			else if (p == 13 || p == 16) begin
				if (b != CHAR_COLON) err[0] = 1'b1;
			end else if (p == 14 || p == 15)
				mi = push_digit(mi, b, 'h7F);
			else if (p == 17 || p == 18)
				sc = push_digit(sc, b, 'h7F);
			else if (p == BASE_LEN) begin
				if (b != CHAR_DOT) err[2] = 1'b1;
			end else begin
				// bytes past the last position all land here as fraction bytes
				if (fcnt < 15) fcnt++;
				if (!dig || fcnt > FRACTION_DIGITS)
					err[3] = 1'b1;
				else
					fr = (fr * 10 + (int'(b) - int'(CHAR_ZERO))) & 'h3FFFFFFF;
			end
			if (pos < 31) pos++;
			if (!fin) return;

			len = p + 1;
			ns = '0;
			st = ST_OK;
			if (len < BASE_LEN || err[0])
				st = ST_FORMAT;
			else if (err[1])
				st = ST_NONDIGIT;
			else if (mon < 1 || mon > 12 || dy < 1 || dy > days_in_month(yr, mon) ||
					hr > 23 || mi > 59 || sc > 59)
				st = ST_RANGE;
			else if (len > BASE_LEN && err[2])
				st = ST_FRAC_SEP;
			else if (len > BASE_LEN && (len == BASE_LEN + 1 || err[3]))
				st = ST_FRAC_DIGITS;
			else begin
				// count years from a March origin, shifted 400 years to keep it positive
				yy = longint'(yr) + 400;
				if (mon <= 2) yy = yy - 1;
				mp = (mon > 2) ? mon - 3 : mon + 9;
				days = yy * 365 + yy / 4 - yy / 100 + yy / 400 +
					longint'((153 * mp + 2) / 5) + longint'(dy) - 1 - 719468 - 146097;
				secs = days * 86400 + longint'(hr) * 3600 + longint'(mi) * 60 +
					longint'(sc);
				frac_ns = longint'(fr);
				for (i = fcnt; i < 9; i++)
					frac_ns = frac_ns * 10;
				fits = (secs > -64'sd9223372037 && secs < 64'sd9223372036) ||
					(secs == 64'sd9223372036 && frac_ns <= 64'sd854775807) ||
					(secs == -64'sd9223372037 && frac_ns >= 64'sd145224192);
				if (fits)
					ns = secs * 64'sd1000000000 + frac_ns;
				else
					st = ST_OVERFLOW;
			end
			exp_ns.insert(exp_ns.size(), ns);
			exp_st.insert(exp_st.size(), st);
			clear();
		endfunction

		function void check_result(logic signed [63:0] ns, logic [2:0] st);
			logic signed [63:0] e_ns;
			status_t e_st;
			if (exp_st.size() == 0) begin
				$display("%0t: unexpected result: epoch_ns %0d status %0d",
					$time, ns, st);
				errors++;
				return;
			end
			e_ns = exp_ns.pop_front();
			e_st = exp_st.pop_front();
			if (st !== e_st) begin
				$display("%0t: status mismatch: expected %0d (%s), actual %0d",
					$time, e_st, e_st.name(), st);
				errors++;
			end
			if (ns !== e_ns) begin
				$display("%0t: epoch_ns mismatch: expected %0d, actual %0d",
					$time, e_ns, ns);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic text_valid = 1'b0;
	logic [7:0] text_byte = '0;
	logic last_byte = 1'b0;
	logic result_stall = 1'b0;
	logic calm = 1'b0;
	logic pressure_req = 1'b0;
	wire logic text_stall;
	wire logic result_valid;
	wire logic signed [63:0] epoch_ns;
	wire logic [2:0] status;

	epoch_scoreboard sb;
	int cycles = 0;

	string directed_texts[$] = '{
		"1970-01-01 00:00:00",
		"1969-12-31 23:59:59.999999999",
		"2262-04-11 23:47:16.854775807",
		"2262-04-11 23:47:16.854775808",
		"2262-04-11 23:47:16.9",
		"1677-09-21 00:12:43.145224192",
		"1677-09-21 00:12:43.145224191",
		"0000-01-01 00:00:00",
		"9999-12-31 23:59:59.999999999",
		"2000-02-29 12:34:56.5",
		"1900-02-29 00:00:00",
		"2023-02-29 00:00:00",
		"2024-02-29 00:00:00.000000001",
		"2024-04-31 00:00:00",
		"2024-00-10 00:00:00",
		"2024-13-10 00:00:00",
		"2024-05-00 00:00:00",
		"2024-05-10 24:00:00",
		"2024-05-10 23:60:00",
		"2024-05-10 23:59:60",
		"2024-05-10T23:59:59",
		"2024/05-10 23:59:59",
		"2024-05-10 23:59:5",
		"7",
		"2O24-05-10 23:59:59",
		"2024-05-10 23:59:59,123",
		"2024-05-10 23:59:59.",
		"2024-05-10 23:59:59.1234567890",
		"2024-05-10 23:59:59.12a",
		"2024-05-10 23:59:59.123456789012345678"
	};

	timestamp_text_to_epoch_ns_top DUT (
		.clk               (clk),
		.arst_n            (arst_n),
		.text_valid        (text_valid),
		.text_stall        (text_stall),
		.text_byte         (text_byte),
		.last_byte         (last_byte),
		.result_valid      (result_valid),
		.result_stall      (result_stall),
		.epoch_ns          (epoch_ns),
		.status            (status)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off on request
	initial begin
		int hold_left;
		bit pressure_done;
		hold_left = 0;
		pressure_done = 1'b0;
		forever begin
			@(posedge clk);
			if (pressure_req && !pressure_done) begin
				hold_left = PRESSURE_CYCLES;
				pressure_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				result_stall <= 1'b1;
			end else
				result_stall <= !calm && ($urandom_range(99) < 31);
		end
	end

	// everything settles before the falling edge, so sample the handshake there
	always @(negedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0)
			sb.check_result(epoch_ns, status);
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		bit taken;
		if (!calm) begin
			while ($urandom_range(99) < 31) begin
				text_valid <= 1'b0;
				@(posedge clk);
			end
		end
		text_valid <= 1'b1;
		text_byte <= b;
		last_byte <= fin;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !text_stall;
			if (taken) sb.take_byte(b, fin);
			@(posedge clk);
		end
	endtask

	task automatic send_text(input text_q_t q);
		for (int i = 0; i < q.size(); i++)
			send_byte(q[i], i == q.size() - 1);
	endtask

	function automatic text_q_t random_text();
		text_q_t q;
		string s;
		int yr, mon, dy, hr, mi, sc, nfrac, cut, pos, k;
		// pure noise now and then
		if ($urandom_range(19) == 0) begin
			k = $urandom_range(40, 1);
			repeat (k) q.insert(q.size(), 8'($urandom_range(255)));
			return q;
		end
		case ($urandom_range(9)) inside
			0, 1, 2, 3, 4, 5: yr = $urandom_range(2261, 1678);
			6:       yr = $urandom_range(1980, 1960);
			7:       yr = $urandom_range(1) ? $urandom_range(1677, 1676) :
				$urandom_range(2263, 2262);
			default: yr = $urandom_range(9999, 0);
		endcase
		mon = ($urandom_range(9) == 0) ? $urandom_range(99) : $urandom_range(12, 1);
		case ($urandom_range(9)) inside
			0:       dy = $urandom_range(99);
			1, 2:    dy = $urandom_range(31, 29);
			default: dy = $urandom_range(28, 1);
		endcase
		hr = ($urandom_range(14) == 0) ? $urandom_range(99) : $urandom_range(23);
		mi = ($urandom_range(14) == 0) ? $urandom_range(99) : $urandom_range(59);
		sc = ($urandom_range(14) == 0) ? $urandom_range(99) : $urandom_range(59);
		s = $sformatf("%04d-%02d-%02d %02d:%02d:%02d", yr, mon, dy, hr, mi, sc);
		case ($urandom_range(19)) inside
			0, 1, 2, 3, 4: nfrac = 0;
			5:             nfrac = $urandom_range(14, 10);
			default:       nfrac = $urandom_range(9, 1);
		endcase
		if (nfrac > 0) begin
			s = {s, "."};
			repeat (nfrac) s = {s, $sformatf("%0d", $urandom_range(9))};
		end
		for (int i = 0; i < s.len(); i++)
			q.insert(q.size(), s[i]);
		// break a fifth of them: corrupt a byte, cut short, or run on
		if ($urandom_range(4) == 0) begin
			case ($urandom_range(2))
				0: begin
					pos = $urandom_range(q.size() - 1);
					q[pos] = 8'($urandom_range(255));
				end
				1: begin
					cut = $urandom_range(q.size(), 1);
					while (q.size() > cut) void'(q.pop_back());
				end
				default: repeat ($urandom_range(20, 1))
					q.insert(q.size(), 8'($urandom_range(255)));
			endcase
		end
		return q;
	endfunction

	initial begin
		text_q_t q;
		int n_bytes, n_texts;
		sb = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_texts[j]) begin
			q.delete();
			for (int i = 0; i < directed_texts[j].len(); i++)
				q.insert(q.size(), directed_texts[j][i]);
			send_text(q);
		end

		n_bytes = 0;
		n_texts = 0;
		while (n_bytes < RANDOM_BYTES) begin
			if (n_texts == 5) calm <= 1'b1;
			if (n_texts == 17) calm <= 1'b0;
			if (n_texts == 20) pressure_req <= 1'b1;
			q = random_text();
			send_text(q);
			n_bytes += q.size();
			n_texts++;
		end
		text_valid <= 1'b0;

		while (sb.exp_st.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (sb.errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
